/* rtl/core/cat_pkg.sv */
package cat_pkg;

  localparam int MAX_NODES  = 4096;
  localparam int NODE_BITS  = $clog2(MAX_NODES);
  localparam int COORD_BITS = 10;

  // port field widths
  localparam int IN_NODE_W   = 12;
  localparam int IN_COORD_W  = 10;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 200;
  localparam int AREA_W      = 31;
  localparam int VOL_W       = 31;
  localparam int DIAG_W      = 22;
  localparam int INER_W      = 60;
  localparam int MEAN_W      = 18;

  // record fields
  localparam int CNT_W  = 31;
  localparam int SUM_W  = COORD_BITS + 30;
  localparam int R2_W   = 2 * COORD_BITS + 32;
  localparam int EXT_W  = COORD_BITS + 1;
  localparam int HALF_W = (SUM_W + 1) / 2;
  localparam logic [CNT_W-1:0] AREA_MAX = CNT_W'(31'h4000_0000);

  // count / 6 as a reciprocal multiply, exact for counts below 2^32
  localparam logic [31:0] RECIP6    = 32'hAAAA_AAAB;
  localparam int          RECIP6_SH = 34;

  // divider
  localparam int DVD_W       = 2 * SUM_W + 2;
  localparam int DSR_W       = CNT_W + 2;
  localparam int STEP_W      = $clog2(DVD_W + 1);
  localparam int F_STEPS     = DSR_W + 9;
  localparam int MEAN_STEPS  = SUM_W + 8;

  typedef enum logic [2:0] {
    REQ_NEW   = 3'd0,
    REQ_ADD   = 3'd1,
    REQ_MERGE = 3'd2,
    REQ_CLONE = 3'd3,
    REQ_QUERY = 3'd4,
    REQ_NOP   = 3'd5
  } req_kind_t;

  typedef struct packed {
    req_kind_t              kind;
    logic [NODE_BITS-1:0]   target;
    logic [NODE_BITS-1:0]   first;
    logic [NODE_BITS-1:0]   second;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [COORD_BITS-1:0]  z;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]      cnt;
    logic [SUM_W-1:0]      sx;
    logic [SUM_W-1:0]      sy;
    logic [SUM_W-1:0]      sz;
    logic [R2_W-1:0]       r2;
    logic [COORD_BITS-1:0] lox;
    logic [COORD_BITS-1:0] loy;
    logic [COORD_BITS-1:0] loz;
    logic [COORD_BITS-1:0] hix;
    logic [COORD_BITS-1:0] hiy;
    logic [COORD_BITS-1:0] hiz;
  } rec_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mz;
    logic [MEAN_W-1:0] my;
    logic [MEAN_W-1:0] mx;
    logic [INER_W-1:0] inertia;
    logic [DIAG_W-1:0] diag;
    logic [VOL_W-1:0]  vol;
    logic [AREA_W-1:0] area;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dvd;
    logic [DSR_W-1:0]  dsr;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_EXEC, S_VOL, S_VOL2, S_SQ, S_SQ_END,
    S_DIV_GO, S_DIV_WAIT, S_NUM, S_W, S_FIN, S_DONE
  } back_state_t;

  typedef enum logic [2:0] {
    D_S2, D_F, D_MX, D_MY, D_MZ
  } div_op_t;

endpackage

/* rtl/core/cat_front.sv */
module cat_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cat_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [2:0]                     in_tuser,
  output logic                           head_valid,
  output cat_pkg::req_t                  head,
  input  logic                           pop
);
  import cat_pkg::*;

  req_t                  q_r [2];
  logic                  wp_r, rp_r;
  logic [1:0]            cnt_r;
  req_t                  dec;
  logic [IN_NODE_W-1:0]  t_raw, f_raw, s_raw;
  logic [IN_COORD_W-1:0] x_raw, y_raw, z_raw;
  logic                  push, do_pop;

  assign t_raw = in_tdata[IN_NODE_W-1:0];
  assign f_raw = in_tdata[2*IN_NODE_W-1:IN_NODE_W];
  assign s_raw = in_tdata[3*IN_NODE_W-1:2*IN_NODE_W];
  assign x_raw = in_tdata[3*IN_NODE_W+IN_COORD_W-1:3*IN_NODE_W];
  assign y_raw = in_tdata[3*IN_NODE_W+2*IN_COORD_W-1:3*IN_NODE_W+IN_COORD_W];
  assign z_raw = in_tdata[3*IN_NODE_W+3*IN_COORD_W-1:3*IN_NODE_W+2*IN_COORD_W];

  always_comb begin
    if (in_tuser > 3'(REQ_QUERY)) begin
      dec.kind = REQ_NOP;
    end else begin
      dec.kind = req_kind_t'(in_tuser);
    end
    dec.target = t_raw[NODE_BITS-1:0];
    dec.first  = f_raw[NODE_BITS-1:0];
    dec.second = s_raw[NODE_BITS-1:0];
    dec.x      = x_raw[COORD_BITS-1:0];
    dec.y      = y_raw[COORD_BITS-1:0];
    dec.z      = z_raw[COORD_BITS-1:0];
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid & in_tready;
  assign head_valid = (cnt_r != 2'd0);
  assign do_pop     = pop & head_valid;
  assign head       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

endmodule

/* rtl/core/cat_div.sv */
module cat_div (
  input  logic              clk,
  input  logic              rst_n,
  input  cat_pkg::div_req_t req,
  output cat_pkg::div_rsp_t rsp
);
  import cat_pkg::*;

  logic              busy_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DSR_W-1:0]  rem_r, dsr_r, rem_nxt;
  logic [DSR_W:0]    rem_sh;
  logic              ge;

  // restoring divide, one quotient bit per cycle shifted in at the bottom
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_nxt = ge ? DSR_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DSR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= req.steps;
      dvd_r <= req.dvd;
      dsr_r <= req.dsr;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - STEP_W'(1);
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

/* rtl/core/cat_back.sv */
module cat_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  cat_pkg::req_t     head,
  output logic              pop,
  output cat_pkg::div_req_t dreq,
  input  cat_pkg::div_rsp_t drsp,
  output logic              out_valid,
  output cat_pkg::result_t  out_res,
  input  logic              out_ready
);
  import cat_pkg::*;

  back_state_t state_r, state_nxt;
  div_op_t     op_r, op_nxt;

  rec_t                 mem [MAX_NODES];
  rec_t                 rdata_r, rec_a_r, vox, opb, comb, wr_rec;
  logic [NODE_BITS-1:0] rd_addr;
  logic                 wr_en;
  req_t                 cur_r;

  logic                 out_valid_r;
  result_t              out_res_r, res_r;

  // query datapath
  logic [EXT_W-1:0]     ext_x, ext_y, ext_z;
  logic [2*EXT_W-1:0]   m1_r;
  logic [DIAG_W-1:0]    diag_r;
  logic [VOL_W-1:0]     vol_r;
  logic [3*EXT_W-1:0]   vol_full;
  logic [2*EXT_W+1:0]   diag_full;
  logic [3:0]           sq_cnt_r;
  logic [SUM_W-1:0]     sq_src;
  logic [HALF_W-1:0]    sq_a, sq_b;
  logic [2*HALF_W-1:0]  prod_r;
  logic [1:0]           prod_sh_r;
  logic                 prod_v_r;
  logic [DVD_W-1:0]     acc_r, prod_ext;
  logic [DVD_W-1:0]     q_r;
  logic [CNT_W-1:0]     rq_r, a6_r;
  logic [CNT_W+31:0]    n6_prod;
  logic [2:0]           ra_r;
  logic                 neg_r;
  logic [DSR_W-1:0]     mag_r;
  logic [7:0]           fq_r;
  logic                 frem_r;
  logic [MEAN_W-1:0]    mx_r, my_r, mz_r, mean_sat;
  logic [R2_W:0]        p_val, w_val;
  logic [R2_W-1:0]      w_r;
  logic                 zero_r, max_r;
  logic [DSR_W+1:0]     ra_n, r6;
  logic [INER_W-1:0]    wsh, inertia;
  logic [8:0]           fmag;
  logic [INER_W:0]      vsum;
  logic [DSR_W+8:0]     f_dvd;
  logic [SUM_W+7:0]     m_dvd;
  logic [SUM_W-1:0]     m_src;

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  // ---------------- record store ----------------
  always_comb begin
    if (state_r == S_RDB) begin
      rd_addr = cur_r.second;
    end else if (cur_r.kind == REQ_ADD || cur_r.kind == REQ_QUERY) begin
      rd_addr = cur_r.target;
    end else begin
      rd_addr = cur_r.first;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wr_en) mem[cur_r.target] <= wr_rec;
  end

  // single voxel as a record; add is a merge with it
  always_comb begin
    logic [R2_W:0] r2s;
    r2s = (R2_W+1)'(cur_r.x * cur_r.x) + (R2_W+1)'(cur_r.y * cur_r.y)
        + (R2_W+1)'(cur_r.z * cur_r.z);
    vox.cnt = CNT_W'(1);
    vox.sx  = SUM_W'(cur_r.x);
    vox.sy  = SUM_W'(cur_r.y);
    vox.sz  = SUM_W'(cur_r.z);
    vox.r2  = r2s[R2_W] ? '1 : r2s[R2_W-1:0];
    vox.lox = cur_r.x; vox.hix = cur_r.x;
    vox.loy = cur_r.y; vox.hiy = cur_r.y;
    vox.loz = cur_r.z; vox.hiz = cur_r.z;
  end

  always_comb begin
    logic [CNT_W:0] cs;
    logic [R2_W:0]  rs;
    opb  = (cur_r.kind == REQ_MERGE) ? rdata_r : vox;
    cs   = {1'b0, rec_a_r.cnt} + {1'b0, opb.cnt};
    rs   = {1'b0, rec_a_r.r2} + {1'b0, opb.r2};
    comb.cnt = (cs > {1'b0, AREA_MAX}) ? AREA_MAX : cs[CNT_W-1:0];
    comb.sx  = sat_sum(rec_a_r.sx, opb.sx);
    comb.sy  = sat_sum(rec_a_r.sy, opb.sy);
    comb.sz  = sat_sum(rec_a_r.sz, opb.sz);
    comb.r2  = rs[R2_W] ? '1 : rs[R2_W-1:0];
    comb.lox = (opb.lox < rec_a_r.lox) ? opb.lox : rec_a_r.lox;
    comb.loy = (opb.loy < rec_a_r.loy) ? opb.loy : rec_a_r.loy;
    comb.loz = (opb.loz < rec_a_r.loz) ? opb.loz : rec_a_r.loz;
    comb.hix = (opb.hix > rec_a_r.hix) ? opb.hix : rec_a_r.hix;
    comb.hiy = (opb.hiy > rec_a_r.hiy) ? opb.hiy : rec_a_r.hiy;
    comb.hiz = (opb.hiz > rec_a_r.hiz) ? opb.hiz : rec_a_r.hiz;
  end

  always_comb begin
    unique case (cur_r.kind)
      REQ_NEW:   wr_rec = vox;
      REQ_CLONE: wr_rec = rec_a_r;
      default:   wr_rec = comb;
    endcase
  end

  assign wr_en = (state_r == S_EXEC) && (cur_r.kind == REQ_NEW || cur_r.kind == REQ_ADD ||
                 cur_r.kind == REQ_MERGE || cur_r.kind == REQ_CLONE);

  // ---------------- query arithmetic ----------------
  assign ext_x = EXT_W'({1'b0, rec_a_r.hix} - {1'b0, rec_a_r.lox} + EXT_W'(1));
  assign ext_y = EXT_W'({1'b0, rec_a_r.hiy} - {1'b0, rec_a_r.loy} + EXT_W'(1));
  assign ext_z = EXT_W'({1'b0, rec_a_r.hiz} - {1'b0, rec_a_r.loz} + EXT_W'(1));
  assign diag_full = (2*EXT_W+2)'(ext_x * ext_x) + (2*EXT_W+2)'(ext_y * ext_y)
                   + (2*EXT_W+2)'(ext_z * ext_z);
  assign vol_full  = m1_r * (2*EXT_W)'(ext_z);

  // area / 6 by reciprocal multiply; the quotient is registered in S_VOL, the remainder in S_VOL2
  assign n6_prod = (CNT_W+32)'(rec_a_r.cnt) * (CNT_W+32)'(RECIP6);

  always_comb begin
    case (sq_cnt_r[3:2])
      2'd0:    sq_src = rec_a_r.sx;
      2'd1:    sq_src = rec_a_r.sy;
      default: sq_src = rec_a_r.sz;
    endcase
    sq_a = sq_cnt_r[1] ? HALF_W'(sq_src >> HALF_W) : sq_src[HALF_W-1:0];
    sq_b = sq_cnt_r[0] ? HALF_W'(sq_src >> HALF_W) : sq_src[HALF_W-1:0];
    case (prod_sh_r)
      2'd0:    prod_ext = DVD_W'(prod_r);
      2'd3:    prod_ext = DVD_W'(prod_r) << (2*HALF_W);
      default: prod_ext = DVD_W'(prod_r) << HALF_W;
    endcase
  end

  assign ra_n = (DSR_W+2)'(ra_r * rec_a_r.cnt);
  assign r6   = (DSR_W+2)'({rq_r, 2'b00}) + (DSR_W+2)'({rq_r, 1'b0});
  assign p_val = {1'b0, rec_a_r.r2} + (R2_W+1)'(a6_r);
  assign w_val = (R2_W+1)'(p_val - (R2_W+1)'(q_r));
  assign f_dvd = {mag_r, 8'h00};
  assign mean_sat = (drsp.quot >> MEAN_W) != '0 ? '1 : drsp.quot[MEAN_W-1:0];

  always_comb begin
    case (op_r)
      D_MY:    m_src = rec_a_r.sy;
      D_MZ:    m_src = rec_a_r.sz;
      default: m_src = rec_a_r.sx;
    endcase
    m_dvd = {m_src, 8'h00};
  end

  assign wsh  = {w_r, 8'h00};
  assign fmag = 9'(fq_r) + 9'(neg_r & frem_r);
  assign vsum = {1'b0, wsh} + (INER_W+1)'(fmag);

  always_comb begin
    if (zero_r) begin
      inertia = '0;
    end else if (max_r) begin
      inertia = '1;
    end else if (neg_r) begin
      inertia = (wsh < INER_W'(fmag)) ? '0 : INER_W'(wsh - INER_W'(fmag));
    end else begin
      inertia = vsum[INER_W] ? '1 : vsum[INER_W-1:0];
    end
  end

  // divider operands
  always_comb begin
    dreq.start = (state_r == S_DIV_GO);
    dreq.dsr   = DSR_W'(rec_a_r.cnt);
    dreq.dvd   = acc_r;
    dreq.steps = STEP_W'(DVD_W);
    case (op_r)
      D_F: begin
        dreq.dsr   = DSR_W'({rec_a_r.cnt, 2'b00}) + DSR_W'({rec_a_r.cnt, 1'b0});
        dreq.dvd   = DVD_W'(f_dvd) << (DVD_W - F_STEPS);
        dreq.steps = STEP_W'(F_STEPS);
      end
      D_MX, D_MY, D_MZ: begin
        dreq.dvd   = DVD_W'(m_dvd) << (DVD_W - MEAN_STEPS);
        dreq.steps = STEP_W'(MEAN_STEPS);
      end
      default: ;
    endcase
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= D_S2;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          state_nxt = S_RDA;
        end
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: state_nxt = S_EXEC;
      S_EXEC: state_nxt = (cur_r.kind == REQ_QUERY) ? S_VOL : S_DONE;
      S_VOL: state_nxt = S_VOL2;
      S_VOL2: state_nxt = S_SQ;
      S_SQ: if (sq_cnt_r == 4'd11) state_nxt = S_SQ_END;
      S_SQ_END: begin
        op_nxt    = D_S2;
        state_nxt = (rec_a_r.cnt == '0) ? S_W : S_DIV_GO;
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (drsp.done) begin
          unique case (op_r)
            D_S2: state_nxt = S_NUM;
            D_F:  begin op_nxt = D_MX; state_nxt = S_DIV_GO; end
            D_MX: begin op_nxt = D_MY; state_nxt = S_DIV_GO; end
            D_MY: begin op_nxt = D_MZ; state_nxt = S_DIV_GO; end
            D_MZ: state_nxt = S_W;
            default: state_nxt = S_W;
          endcase
        end
      end
      S_NUM: begin op_nxt = D_F; state_nxt = S_DIV_GO; end
      S_W: state_nxt = S_FIN;
      S_FIN: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    prod_v_r <= 1'b0;
    if (state_r == S_IDLE && head_valid) cur_r <= head;
    if (state_r == S_RDB) rec_a_r <= rdata_r;
    if (state_r == S_EXEC) res_r <= '0;
    if (state_r == S_VOL) begin
      m1_r   <= ext_x * ext_y;
      diag_r <= (diag_full >> DIAG_W) != '0 ? '1 : diag_full[DIAG_W-1:0];
      q_r    <= '0;
      rq_r   <= '0;
      a6_r   <= CNT_W'(n6_prod >> RECIP6_SH);
      neg_r  <= 1'b0;
      mag_r  <= '0;
      fq_r   <= '0;
      frem_r <= 1'b0;
      mx_r   <= '0;
      my_r   <= '0;
      mz_r   <= '0;
    end
    if (state_r == S_VOL2) begin
      vol_r    <= (vol_full >> VOL_W) != '0 ? '1 : vol_full[VOL_W-1:0];
      sq_cnt_r <= 4'd0;
      acc_r    <= '0;
      ra_r     <= 3'(rec_a_r.cnt - {a6_r[CNT_W-3:0], 2'b00} - {a6_r[CNT_W-2:0], 1'b0});
    end
    if (state_r == S_SQ) begin
      prod_r    <= sq_a * sq_b;
      prod_sh_r <= sq_cnt_r[1:0];
      prod_v_r  <= 1'b1;
      sq_cnt_r  <= sq_cnt_r + 4'd1;
    end
    if (prod_v_r) acc_r <= acc_r + prod_ext;
    if (state_r == S_DIV_WAIT && drsp.done) begin
      case (op_r)
        D_S2: begin q_r <= drsp.quot; rq_r <= drsp.rem[CNT_W-1:0]; end
        D_F:  begin fq_r <= drsp.quot[7:0]; frem_r <= (drsp.rem != '0); end
        D_MX: mx_r <= mean_sat;
        D_MY: my_r <= mean_sat;
        default: mz_r <= mean_sat;
      endcase
    end
    if (state_r == S_NUM) begin
      neg_r <= (ra_n < r6);
      mag_r <= (ra_n < r6) ? DSR_W'(r6 - ra_n) : DSR_W'(ra_n - r6);
    end
    if (state_r == S_W) begin
      zero_r <= (q_r > DVD_W'(p_val));
      max_r  <= w_val[R2_W];
      w_r    <= w_val[R2_W-1:0];
    end
    if (state_r == S_FIN) begin
      res_r.area    <= rec_a_r.cnt;
      res_r.vol     <= vol_r;
      res_r.diag    <= diag_r;
      res_r.inertia <= inertia;
      res_r.mx      <= mx_r;
      res_r.my      <= my_r;
      res_r.mz      <= mz_r;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) out_res_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* rtl/core/component_attribute_table.sv */
// Update requests (new, add, merge, clone) do one read-modify-write of a record; a
// query reads a record and runs the query arithmetic and the bit-serial divider.
// The back end takes one request at a time; the query time is set by the divider,
// which runs up to five divisions in turn, and updates by one read-modify-write.
// A two-beat request queue keeps accepting while the back end works, until it is full.
// Reset: synchronous, active low; clears control only, records are undefined until written.
module component_attribute_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // target_node, first_node, second_node, coord_x, coord_y, coord_z, zero pad
  input  logic [cat_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic [2:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // area, box_volume, diag_squared, inertia_fixed, mean_x/y/z_fixed, zero pad
  output logic [cat_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cat_pkg::*;

  logic     head_valid, pop;
  req_t     head;
  div_req_t dreq;
  div_rsp_t drsp;
  result_t  res;

  cat_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  cat_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  cat_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .dreq       (dreq),
    .drsp       (drsp),
    .out_valid  (out_tvalid),
    .out_res    (res),
    .out_ready  (out_tready)
  );

  assign out_tdata = {2'b00, res.mz, res.my, res.mx, res.inertia, res.diag, res.vol, res.area};

endmodule

/* rtl/core/cat_checker.sv */
module cat_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cat_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a beat offered downstream is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped before it was taken");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // area is saturated, and a box of 10-bit coordinates holds at most 2^30 voxels
  a_area_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[30:0] <= 31'h4000_0000)
    else $error("area above saturation limit");

  // a result cannot show up in the same cycle reset is released with nothing accepted
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result without an accepted request");

endmodule

bind component_attribute_table cat_checker u_cat_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
